// ===== hdl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helpers of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned USED_W = 3;
  localparam int unsigned CNT_W  = 2;

  // replacement character
  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // limits for overlong, surrogate and out-of-range sequences
  localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD3_LOW   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_SURR  = 8'hED;
  localparam logic [BYTE_W-1:0] CONT3_MIN   = 8'hA0;
  localparam logic [BYTE_W-1:0] LEAD4_LOW   = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT4_MIN   = 8'h90;
  localparam logic [BYTE_W-1:0] LEAD4_HIGH  = 8'hF4;
  localparam logic [BYTE_W-1:0] CONT4_MAX   = 8'h8F;

  // results of one byte, handed from decode to emit
  typedef struct packed {
    logic [CNT_W-1:0]  rep_cnt;    // single-byte replacements first
    logic              tail_vld;   // then one more result
    logic [CP_W-1:0]   tail_cp;
    logic              tail_rep;
    logic [USED_W-1:0] tail_used;
  } burst_t;

  // sequence length announced by a lead byte, 0 for a byte that cannot lead
  function automatic logic [USED_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [USED_W-1:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

endpackage

// ===== hdl/utf8d_in_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_in_if
// Byte channel into the decoder: valid/ready with one text byte.
// ----------------------------------------------------------------------------
interface utf8d_in_if import utf8d_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ===== hdl/utf8d_out_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_out_if
// Code point channel out of the decoder: valid/ready with one result.
// ----------------------------------------------------------------------------
interface utf8d_out_if import utf8d_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   code_point;
  logic              is_replacement;
  logic [USED_W-1:0] bytes_used;
  logic              run_last;

  modport source (output valid, output code_point, output is_replacement,
                  output bytes_used, output run_last, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input bytes_used, input run_last, output ready);
endinterface

// ===== hdl/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Input register, sequence state and the single-pass byte decoder.
// ----------------------------------------------------------------------------
module utf8d_decode import utf8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  utf8d_in_if.sink   in_i,
  output burst_t     burst_o,
  output logic       burst_valid_o,
  input  logic       burst_ready_i
);

  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_eot_q;

  logic [CNT_W-1:0]  held_cnt_q, held_cnt_d;
  logic [USED_W-1:0] seq_len_q, seq_len_d;
  logic [BYTE_W-1:0] held0_q, held0_d;
  logic [BYTE_W-1:0] held1_q, held1_d;
  logic [BYTE_W-1:0] held2_q, held2_d;

  logic [USED_W-1:0] byte_len;
  logic              is_cont;
  logic [USED_W-1:0] cnt_inc;
  logic [BYTE_W-1:0] c2, c3;
  logic              fin_bad;
  logic [CP_W-1:0]   fin_cp;
  burst_t            burst;
  logic              has_res;
  logic              advance;
  logic              in_load;

  assign byte_len = lead_len(in_byte_q);
  assign is_cont  = (in_byte_q[7:6] == 2'b10);
  assign cnt_inc  = {1'b0, held_cnt_q} + 3'd1;

  // completion of a held sequence with the current byte as its last one
  always_comb begin
    c2 = (seq_len_q == 3'd2) ? in_byte_q : held1_q;
    c3 = (seq_len_q == 3'd3) ? in_byte_q : held2_q;
    unique case (seq_len_q)
      3'd2: begin
        fin_bad = (held0_q < LEAD2_MIN);
        fin_cp  = {10'd0, held0_q[4:0], c2[5:0]};
      end
      3'd3: begin
        fin_bad = ((held0_q == LEAD3_LOW) && (c2 < CONT3_MIN)) ||
                  ((held0_q == LEAD3_SURR) && (c2 >= CONT3_MIN));
        fin_cp  = {5'd0, held0_q[3:0], c2[5:0], c3[5:0]};
      end
      default: begin
        fin_bad = ((held0_q == LEAD4_LOW) && (c2 < CONT4_MIN)) ||
                  ((held0_q == LEAD4_HIGH) && (c2 > CONT4_MAX)) ||
                  (held0_q > LEAD4_HIGH);
        fin_cp  = {held0_q[2:0], c2[5:0], c3[5:0], in_byte_q[5:0]};
      end
    endcase
  end

  always_comb begin
    burst.rep_cnt   = '0;
    burst.tail_vld  = 1'b0;
    burst.tail_cp   = REPL_CP;
    burst.tail_rep  = 1'b1;
    burst.tail_used = 3'd1;
    held_cnt_d      = held_cnt_q;
    seq_len_d       = seq_len_q;
    held0_d         = held0_q;
    held1_d         = held1_q;
    held2_d         = held2_q;

    if ((held_cnt_q != '0) && is_cont) begin
      if (cnt_inc >= seq_len_q) begin
        burst.tail_vld  = 1'b1;
        burst.tail_used = seq_len_q;
        burst.tail_rep  = fin_bad;
        burst.tail_cp   = fin_bad ? REPL_CP : fin_cp;
        held_cnt_d      = '0;
        seq_len_d       = '0;
      end else begin
        if (held_cnt_q == 2'd1) begin
          held1_d = in_byte_q;
        end else begin
          held2_d = in_byte_q;
        end
        held_cnt_d = cnt_inc[CNT_W-1:0];
        // text ends inside the sequence
        if (in_eot_q) begin
          burst.rep_cnt = cnt_inc[CNT_W-1:0];
          held_cnt_d    = '0;
          seq_len_d     = '0;
        end
      end
    end else begin
      // flush whatever was held, then treat the byte as a lead
      burst.rep_cnt = held_cnt_q;
      held_cnt_d    = '0;
      seq_len_d     = '0;
      if (byte_len == 3'd1) begin
        burst.tail_vld = 1'b1;
        burst.tail_cp  = {13'd0, in_byte_q};
        burst.tail_rep = 1'b0;
      end else if ((byte_len == 3'd0) || in_eot_q) begin
        burst.tail_vld = 1'b1;
      end else begin
        held0_d    = in_byte_q;
        held_cnt_d = 2'd1;
        seq_len_d  = byte_len;
      end
    end
  end

  assign has_res       = (burst.rep_cnt != '0) || burst.tail_vld;
  assign advance       = in_vld_q && (burst_ready_i || !has_res);
  assign in_i.ready    = !in_vld_q || advance;
  assign in_load       = in_i.valid && in_i.ready;
  assign burst_o       = burst;
  assign burst_valid_o = in_vld_q && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      held_cnt_q <= '0;
      seq_len_q  <= '0;
    end else begin
      if (in_load) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        held_cnt_q <= held_cnt_d;
        seq_len_q  <= seq_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= in_i.in_byte;
      in_eot_q  <= in_i.end_of_text;
    end
    if (advance) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
      held2_q <= held2_d;
    end
  end

endmodule

// ===== hdl/utf8d_emit.sv =====
// ----------------------------------------------------------------------------
// utf8d_emit
// Holds the results of one byte and sends them out one per transaction.
// ----------------------------------------------------------------------------
module utf8d_emit import utf8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  burst_t     burst_i,
  input  logic       burst_valid_i,
  output logic       burst_ready_o,
  utf8d_out_if.source out_o
);

  logic              burst_vld_q;
  logic [CNT_W-1:0]  rep_q;
  logic              tail_vld_q;
  logic [CP_W-1:0]   tail_cp_q;
  logic              tail_rep_q;
  logic [USED_W-1:0] tail_used_q;

  logic              out_vld_q;
  logic [CP_W-1:0]   cp_q;
  logic              repl_q;
  logic [USED_W-1:0] used_q;
  logic              last_q;

  logic out_load;
  logic emit;
  logic burst_last;
  logic burst_load;

  assign out_load      = !out_vld_q || out_o.ready;
  assign emit          = burst_vld_q && out_load;
  assign burst_last    = tail_vld_q ? (rep_q == '0) : (rep_q == 2'd1);
  assign burst_ready_o = !burst_vld_q || (emit && burst_last);
  assign burst_load    = burst_valid_i && burst_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (burst_load) begin
        burst_vld_q <= 1'b1;
      end else if (emit && burst_last) begin
        burst_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_load) begin
      rep_q       <= burst_i.rep_cnt;
      tail_vld_q  <= burst_i.tail_vld;
      tail_cp_q   <= burst_i.tail_cp;
      tail_rep_q  <= burst_i.tail_rep;
      tail_used_q <= burst_i.tail_used;
    end else if (emit && (rep_q != '0)) begin
      rep_q <= rep_q - 2'd1;
    end
    if (emit) begin
      last_q <= burst_last;
      if (rep_q != '0) begin
        cp_q   <= REPL_CP;
        repl_q <= 1'b1;
        used_q <= 3'd1;
      end else begin
        cp_q   <= tail_cp_q;
        repl_q <= tail_rep_q;
        used_q <= tail_used_q;
      end
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.code_point     = cp_q;
  assign out_o.is_replacement = repl_q;
  assign out_o.bytes_used     = used_q;
  assign out_o.run_last       = last_q;

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 to code point decoder with U+FFFD substitution.
// ----------------------------------------------------------------------------
// usage
//   in_i  : one text byte per transaction, end_of_text set on the final byte
//   out_o : one code point per transaction; bytes_used tells how many input
//           bytes it covers, run_last marks the last result of a byte
//   a byte that only extends a held sequence gives no result at all; a byte
//   that breaks a sequence gives one replacement per held byte before any result
//   of its own, so one byte gives 0 to 4 results
// timing
//   the first result of a byte passes the input register, the result burst
//   register and the output register in turn before it is valid on out_o
//   one byte per cycle while each byte gives at most one result and out_o is
//   ready; a byte with several results holds the input side while the single
//   output register emits them one per cycle, as out_o.ready allows
// reset
//   rst_ni clears all valid flags and the held sequence; held bytes are
//   payload only and are never read before being written
// stalls
//   with out_o.ready low the output register keeps its result, the burst
//   register and input register fill, then in_i.ready drops; nothing is lost
// ----------------------------------------------------------------------------
module utf8_stream_decoder import utf8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8d_in_if.sink    in_i,
  utf8d_out_if.source out_o
);

  // results of the byte in the decode stage
  burst_t burst;
  logic   burst_valid;
  logic   burst_ready;

  // input register, sequence state and the byte decoder
  utf8d_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .burst_o       (burst),
    .burst_valid_o (burst_valid),
    .burst_ready_i (burst_ready)
  );

  // serializes the replacements and final result into the output register
  utf8d_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_i       (burst),
    .burst_valid_i (burst_valid),
    .burst_ready_o (burst_ready),
    .out_o         (out_o)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_stream_decoder: a short table of directed
// bytes, then random UTF-8 text, mostly well-formed with broken and noisy
// sequences mixed in. Results are checked against the local decoder model or pinned rows.
// ----------------------------------------------------------------------------
module tb;
  import utf8d_pkg::*;

  localparam int N_RANDOM       = 200;
  localparam int HOLD_AT        = 40;    // results taken before the long hold-off
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 20;    // wait after the last expected result so stray ones are caught
  localparam int WATCHDOG_LIMIT = 2000;

  // one text byte as the sender offers it, with an optional typed-in result
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eot;
    logic              pinned;   // this row carries its own single result
    logic [CP_W-1:0]   cp;
    logic              rep;
    logic [USED_W-1:0] used;
  } text_item_t;

  // one decoded code point as it leaves the block
  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic              rep;
    logic [USED_W-1:0] used;
    logic              last;
  } cp_result_t;

  // directed rows: extremes, stray and bad bytes, overlong, surrogate and out-of-range
  // sequences, interruption and end of text in the middle of a sequence
  localparam int N_DIRECTED = 24;
  localparam text_item_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0, 3'd1},   // lowest ascii
    '{8'h7F, 1'b1, 1'b1, 21'h00007F, 1'b0, 3'd1},   // highest ascii, end of text
    '{8'h80, 1'b0, 1'b1, REPL_CP,    1'b1, 3'd1},   // stray continuation
    '{8'hFF, 1'b0, 1'b1, REPL_CP,    1'b1, 3'd1},   // byte that never leads
    '{8'hC0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // overlong two-byte lead
    '{8'h80, 1'b0, 1'b1, REPL_CP,    1'b1, 3'd2},
    '{8'hED, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // surrogate
    '{8'hA0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'h80, 1'b0, 1'b1, REPL_CP,    1'b1, 3'd3},
    '{8'hF4, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // above the code space
    '{8'h90, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'h80, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'h80, 1'b0, 1'b1, REPL_CP,    1'b1, 3'd4},
    '{8'hF4, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // highest code point
    '{8'h8F, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'hBF, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'hBF, 1'b0, 1'b1, 21'h10FFFF, 1'b0, 3'd4},
    '{8'hF0, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // three held, then ascii
    '{8'h90, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'h80, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'h41, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'hE2, 1'b0, 1'b0, 21'h0,      1'b0, 3'd0},   // end of text mid-sequence
    '{8'h82, 1'b1, 1'b0, 21'h0,      1'b0, 3'd0},
    '{8'hC3, 1'b1, 1'b1, REPL_CP,    1'b1, 3'd1}    // lead that ends the text
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  utf8d_in_if  in_if ();
  utf8d_out_if out_if ();

  utf8_stream_decoder i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  text_item_t text_q [$];       // bytes still to be offered
  text_item_t drive_item;       // byte currently on in_if, with its pin
  cp_result_t expected_cps [$]; // code points predicted, oldest first
  cp_result_t byte_results [$]; // results of the byte being decoded
  int         errors    = 0;
  bit         text_done = 1'b0;

  // decoder model state
  logic [BYTE_W-1:0] held_q [3] = '{default: '0};
  logic [1:0]        held_n  = '0;
  logic [2:0]        seq_len = '0;

  // --------------------------------------------------------------------------
  // decoder model
  // --------------------------------------------------------------------------

  // length announced by a lead byte, 0 when it cannot lead
  function automatic logic [2:0] lead_bytes(input logic [BYTE_W-1:0] b);
    logic [2:0] n;
    casez (b)
      8'b0???????: n = 3'd1;
      8'b110?????: n = 3'd2;
      8'b1110????: n = 3'd3;
      8'b11110???: n = 3'd4;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic void add_result(input logic [CP_W-1:0] cp, input logic rep,
                                     input logic [USED_W-1:0] used);
    cp_result_t r;
    r = '{cp, rep, used, 1'b0};
    byte_results.insert(byte_results.size(), r);
  endfunction

  // one single-byte replacement per held byte, sequence dropped
  function automatic void flush_held();
    repeat (held_n) add_result(REPL_CP, 1'b1, 3'd1);
    held_n  = '0;
    seq_len = '0;
  endfunction

  // sequence complete: one code point, or one replacement for all of it
  function automatic void close_seq(input logic [BYTE_W-1:0] last);
    logic [BYTE_W-1:0] c1, c2, c3;
    logic              bad;
    logic [CP_W-1:0]   cp;
    c1 = held_q[0];
    c2 = (seq_len == 3'd2) ? last : held_q[1];
    c3 = (seq_len == 3'd3) ? last : held_q[2];
    case (seq_len)
      3'd2: begin
        bad = c1 < LEAD2_MIN;
        cp  = {10'b0, c1[4:0], c2[5:0]};
      end
      3'd3: begin
        bad = (c1 == LEAD3_LOW && c2 < CONT3_MIN) || (c1 == LEAD3_SURR && c2 >= CONT3_MIN);
        cp  = {5'b0, c1[3:0], c2[5:0], c3[5:0]};
      end
      default: begin
        bad = (c1 == LEAD4_LOW && c2 < CONT4_MIN) || (c1 == LEAD4_HIGH && c2 > CONT4_MAX)
              || c1 > LEAD4_HIGH;
        cp  = {c1[2:0], c2[5:0], c3[5:0], last[5:0]};
      end
    endcase
    if (bad) add_result(REPL_CP, 1'b1, seq_len);
    else add_result(cp, 1'b0, seq_len);
    held_n  = '0;
    seq_len = '0;
  endfunction

  // fills byte_results with what one accepted byte causes
  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
    logic [2:0] len;
    byte_results.delete();
    if (held_n != 0 && b[7:6] == 2'b10) begin
      // continuation of the held sequence
      if (int'(held_n) + 1 >= int'(seq_len)) begin
        close_seq(b);
      end else begin
        held_q[held_n] = b;
        held_n = held_n + 2'd1;
        if (eot) flush_held();
      end
    end else begin
      // anything else breaks a held sequence, then starts afresh
      if (held_n != 0) flush_held();
      len = lead_bytes(b);
      if (len == 3'd1) begin
        add_result({13'b0, b}, 1'b0, 3'd1);
      end else if (len == 3'd0 || eot) begin
        add_result(REPL_CP, 1'b1, 3'd1);
      end else begin
        held_q[0] = b;
        held_n    = 2'd1;
        seq_len   = len;
      end
    end
    if (byte_results.size() != 0) byte_results[byte_results.size()-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // random text
  // --------------------------------------------------------------------------

  function automatic logic [BYTE_W-1:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // end of text falls on about one byte in twenty
  function automatic void push_text(input logic [BYTE_W-1:0] b);
    text_item_t t;
    t     = '0;
    t.b   = b;
    t.eot = ($urandom_range(0, 19) == 0);
    text_q.insert(text_q.size(), t);
  endfunction

  function automatic void build_random_text();
    logic [BYTE_W-1:0] lead, second, brk;
    int                len, kind, keep;
    while (text_q.size() < N_DIRECTED + N_RANDOM) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1, 2: push_text(8'($urandom_range(0, 127)));
        3, 4: begin
          push_text(8'($urandom_range(8'hC2, 8'hDF)));
          push_text(cont_byte());
        end
        5, 6: begin
          // well-formed three-byte sequence
          lead = 8'($urandom_range(8'hE0, 8'hEF));
          if (lead == LEAD3_LOW) second = 8'($urandom_range(8'hA0, 8'hBF));
          else if (lead == LEAD3_SURR) second = 8'($urandom_range(8'h80, 8'h9F));
          else second = cont_byte();
          push_text(lead);
          push_text(second);
          push_text(cont_byte());
        end
        7, 8: begin
          // well-formed four-byte sequence
          lead = 8'($urandom_range(8'hF0, 8'hF4));
          if (lead == LEAD4_LOW) second = 8'($urandom_range(8'h90, 8'hBF));
          else if (lead == LEAD4_HIGH) second = 8'($urandom_range(8'h80, 8'h8F));
          else second = cont_byte();
          push_text(lead);
          push_text(second);
          push_text(cont_byte());
          push_text(cont_byte());
        end
        9: begin
          // complete sequence from any lead, often overlong or out of range
          lead = 8'($urandom_range(8'hC0, 8'hF7));
          len  = lead_bytes(lead);
          push_text(lead);
          repeat (len - 1) push_text(cont_byte());
        end
        10: begin
          // truncated sequence broken by ascii or a lead
          lead = 8'($urandom_range(8'hC2, 8'hF4));
          len  = lead_bytes(lead);
          keep = $urandom_range(0, len - 2);
          push_text(lead);
          repeat (keep) push_text(cont_byte());
          brk = 8'($urandom_range(0, 175));
          push_text(brk < 8'd128 ? brk : brk + 8'd64);
        end
        default: begin
          if ($urandom_range(0, 2) == 0) push_text(8'($urandom_range(8'hF8, 8'hFF)));
          else push_text(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // outputs are compared first; a byte's results can only show up cycles
  // after its own transaction, so the order of the two parts does not matter
  always @(posedge clk) begin : scoreboard
    cp_result_t got, want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.code_point, out_if.is_replacement, out_if.bytes_used, out_if.run_last};
        if (expected_cps.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual %0h",
                   $time, got.cp);
        end else begin
          want = expected_cps.pop_front();
          check_field("code_point", want.cp, got.cp);
          check_field("is_replacement", want.rep, got.rep);
          check_field("bytes_used", want.used, got.used);
          check_field("run_last", want.last, got.last);
        end
      end
      if (in_if.valid && in_if.ready) begin
        // the model always runs so its state stays in step with the block
        decode_byte(in_if.in_byte, in_if.end_of_text);
        if (drive_item.pinned) begin
          byte_results.delete();
          add_result(drive_item.cp, drive_item.rep, drive_item.used);
          byte_results[0].last = 1'b1;
        end
        foreach (byte_results[i]) expected_cps.insert(expected_cps.size(), byte_results[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender: directed rows, then random text, with random gaps of idle cycles
  // --------------------------------------------------------------------------
  initial begin : sender
    int         gap;
    int         n_sent;
    text_item_t item;
    in_if.valid       = 1'b0;
    in_if.in_byte     = '0;
    in_if.end_of_text = 1'b0;
    drive_item        = '0;
    n_sent            = 0;
    foreach (DIRECTED_ROWS[i]) text_q.insert(text_q.size(), DIRECTED_ROWS[i]);
    build_random_text();
    while (!rst_n) @(posedge clk);
    @(posedge clk);
    while (text_q.size() != 0) begin
      item = text_q.pop_front();
      // the first ten bytes of every forty go back to back
      gap = (n_sent % 40 < 10) ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_if.valid       <= 1'b1;
      in_if.in_byte     <= item.b;
      in_if.end_of_text <= item.eot;
      drive_item        <= item;
      do @(posedge clk); while (!in_if.ready);
      n_sent++;
    end
    in_if.valid <= 1'b0;
    text_done = 1'b1;
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls before transactions, one long hold-off so
  // the block backs up and drops in_if.ready while bytes keep coming
  // --------------------------------------------------------------------------
  initial begin : receiver
    int gap;
    int n_taken;
    bit held_off;
    out_if.ready = 1'b0;
    n_taken      = 0;
    held_off     = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (n_taken == HOLD_AT && !held_off) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = (n_taken % 50 < 12) ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      n_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transaction on either side
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // reset, then wait for the text to go in and every code point to come out
  // --------------------------------------------------------------------------
  initial begin : run_ctrl
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (!text_done) @(posedge clk);
    // let the last byte's results reach the expected queue
    @(posedge clk);
    while (expected_cps.size() != 0) @(posedge clk);
    // anything arriving now is a result nobody asked for
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
